// ===== hdl/cad_pkg.sv =====
// shared types, constants and month-length table for the calendar day adder
`default_nettype none
package cad_pkg;

  // field widths
  localparam int DateW   = 27;
  localparam int OffsetW = 16;
  localparam int YearW   = 14;
  localparam int DayW    = 17;
  localparam int DivisorW = 14;
  localparam int RecipW   = 28;
  localparam int ShiftW   = 6;
  localparam int ProdW    = DateW + RecipW;

  // decimal packing and calendar constants
  localparam int YearScale  = 10000;
  localparam int MonthScale = 100;
  localparam int YearBias   = 400;
  localparam int EraYears   = 400;
  localparam int YearMin    = 1;
  localparam int YearMax    = 9999;

  // reciprocals: (n * recip) >> shift equals n / divisor over the dividends in use
  localparam int RecipYear  = 219902326;
  localparam int ShiftYear  = 41;
  localparam int RecipMonth = 10486;
  localparam int ShiftMonth = 20;
  localparam int RecipEra   = 10486;
  localparam int ShiftEra   = 22;

  // constant divisor select
  typedef enum logic [1:0] {
    DIV_BY_YEAR,
    DIV_BY_MONTH,
    DIV_BY_ERA
  } div_sel_t;

  // one input request
  typedef struct packed {
    logic [DateW-1:0]          date_code;
    logic signed [OffsetW-1:0] day_offset;
  } date_req_t;

  // one result
  typedef struct packed {
    logic [DateW-1:0] result_date;
    logic             range_error;
  } date_rsp_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DateW-1:0] dividend;
    div_sel_t         sel;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DateW-1:0]    quotient;
    logic [DivisorW-1:0] remainder;
  } div_rsp_t;

  // days in a month, leap selects the long february
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cad_div.sv =====
// divide by a decimal constant through reciprocal multiplication; a new request is taken only in idle
`default_nettype none
module cad_div
  import cad_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  typedef enum logic [1:0] {
    IDLE,
    MUL,
    SHIFT,
    REM
  } state_t;

  state_t              state;
  div_sel_t            sel;
  logic [DateW-1:0]    num;
  logic [ProdW-1:0]    prod;
  logic [DateW-1:0]    quo;
  logic [DivisorW-1:0] rem;
  logic                done;

  logic [RecipW-1:0]   recip;
  logic [ShiftW-1:0]   shift;
  logic [DivisorW-1:0] divisor;

  // reciprocal, shift and divisor for the selected constant
  always_comb begin
    case (sel)
      DIV_BY_MONTH: begin
        recip   = RecipW'(RecipMonth);
        shift   = ShiftW'(ShiftMonth);
        divisor = DivisorW'(MonthScale);
      end
      DIV_BY_ERA: begin
        recip   = RecipW'(RecipEra);
        shift   = ShiftW'(ShiftEra);
        divisor = DivisorW'(EraYears);
      end
      default: begin
        recip   = RecipW'(RecipYear);
        shift   = ShiftW'(ShiftYear);
        divisor = DivisorW'(YearScale);
      end
    endcase
  end

  // multiply, shift out the quotient, then take the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (req.start) begin
            num   <= req.dividend;
            sel   <= req.sel;
            state <= MUL;
          end
        end
        MUL: begin
          prod  <= ProdW'(num) * ProdW'(recip);
          state <= SHIFT;
        end
        SHIFT: begin
          quo   <= DateW'(prod >> shift);
          state <= REM;
        end
        REM: begin
          rem   <= DivisorW'(num - DateW'(quo[YearW-1:0]) * DateW'(divisor));
          done  <= 1'b1;
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign rsp = '{done: done, quotient: quo, remainder: rem};

endmodule
`default_nettype wire

// ===== hdl/calendar_add_days_core.sv =====
// calendar day adder: decimal date plus signed day offset, month-by-month walk
// sequence: three decimal splits on the shared reciprocal divider (year, month, era),
//   then a walk that steps one month at a time, then a pack step for the result
// throughput: one request at a time; busy stays high from accept to the done strobe
// the result is shown for one cycle with done and cannot be stalled
// reset clears the sequencer, busy and done; result registers are not cleared
`default_nettype none
module calendar_add_days_core
  import cad_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire date_req_t req,
  output logic           busy,
  output logic           done,
  output date_rsp_t      rsp
);

  typedef enum logic [2:0] {
    IDLE,
    DIV_YEAR,
    DIV_MONTH,
    DIV_ERA,
    WALK,
    PACK
  } state_t;

  state_t state;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [OffsetW-1:0] offset;
  logic [YearW-1:0]          year_raw;
  logic [YearW-1:0]          yb;
  logic [8:0]                ymod;
  logic [3:0]                mon;
  logic [6:0]                day_raw;
  logic signed [DayW-1:0]    d;

  logic       leap;
  logic [4:0] cur_len;
  logic [4:0] prev_len;
  logic [6:0] mon_raw;
  logic [3:0] mon_clamp;
  logic [YearW-1:0] year_out;
  logic       year_bad;

  // shared divider for the decimal splits
  cad_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // leap year, month lengths around the current month, month clamp and year range check
  always_comb begin
    leap      = (ymod[1:0] == 2'd0) &&
                !(ymod == 9'd100 || ymod == 9'd200 || ymod == 9'd300);
    cur_len   = month_len(mon, leap);
    prev_len  = (mon == 4'd1) ? 5'd31 : month_len(mon - 4'd1, leap);
    mon_raw   = div_rsp.quotient[6:0];
    mon_clamp = (mon_raw == 7'd0) ? 4'd1 :
                (mon_raw > 7'd12) ? 4'd12 : mon_raw[3:0];
    year_out  = yb - YearW'(YearBias);
    year_bad  = (yb < YearW'(YearBias + YearMin)) || (yb > YearW'(YearBias + YearMax));
  end

  // sequencer, walk datapath and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      busy          <= 1'b0;
      done          <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      done          <= 1'b0;
      div_req.start <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            offset           <= req.day_offset;
            div_req.start    <= 1'b1;
            div_req.dividend <= req.date_code;
            div_req.sel      <= DIV_BY_YEAR;
            busy             <= 1'b1;
            state            <= DIV_YEAR;
          end
        end
        DIV_YEAR: begin
          if (div_rsp.done) begin
            year_raw         <= div_rsp.quotient[YearW-1:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= {{(DateW-DivisorW){1'b0}}, div_rsp.remainder};
            div_req.sel      <= DIV_BY_MONTH;
            state            <= DIV_MONTH;
          end
        end
        DIV_MONTH: begin
          if (div_rsp.done) begin
            mon              <= mon_clamp;
            day_raw          <= div_rsp.remainder[6:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= {{(DateW-YearW){1'b0}}, year_raw};
            div_req.sel      <= DIV_BY_ERA;
            state            <= DIV_ERA;
          end
        end
        DIV_ERA: begin
          if (div_rsp.done) begin
            yb    <= year_raw + YearW'(YearBias);
            ymod  <= div_rsp.remainder[8:0];
            d     <= {offset[OffsetW-1], offset} + {10'b0, day_raw};
            state <= WALK;
          end
        end
        WALK: begin
          if (d < 17'sd1) begin
            // step back into the previous month
            d <= d + $signed({12'b0, prev_len});
            if (mon == 4'd1) begin
              mon  <= 4'd12;
              yb   <= yb - 14'd1;
              ymod <= (ymod == 9'd0) ? 9'(EraYears - 1) : ymod - 9'd1;
            end else begin
              mon <= mon - 4'd1;
            end
          end else if (d > $signed({12'b0, cur_len})) begin
            // spill into the next month
            d <= d - $signed({12'b0, cur_len});
            if (mon == 4'd12) begin
              mon  <= 4'd1;
              yb   <= yb + 14'd1;
              ymod <= (ymod == 9'(EraYears - 1)) ? 9'd0 : ymod + 9'd1;
            end else begin
              mon <= mon + 4'd1;
            end
          end else begin
            state <= PACK;
          end
        end
        PACK: begin
          rsp.range_error <= year_bad;
          rsp.result_date <= year_bad ? '0 :
                             DateW'(year_out) * DateW'(YearScale) +
                             DateW'(mon) * DateW'(MonthScale) +
                             DateW'(d[6:0]);
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // a result only follows a request in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a request in flight");

  // strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // error results read zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.range_error) |-> (rsp.result_date == '0))
    else $error("range error with nonzero date");

  // month stays legal during the walk
  a_month_legal: assert property (@(posedge clk) disable iff (rst)
    (state == WALK) |-> (mon >= 4'd1 && mon <= 4'd12))
    else $error("month out of range during walk");

endmodule
`default_nettype wire
